[rtl/ppb_pkg.sv]
// Shared types, constants and helpers for the particle push and binning pipeline.
package ppb_pkg;

	// Fixed-point and sizing constants
	localparam int FRAC_BITS = 16;
	localparam int MAX_FOLDS = 2;
	localparam int MAX_CELLS = 4096;

	localparam int Q_W    = 32;
	localparam int STEP_W = 31;
	localparam int MODE_W = 2;
	localparam int CNT_W  = 13;
	localparam int CELL_W = 12;
	localparam int IDX_W  = 3;
	localparam int PROD_W = 64;
	// Folded positions grow by up to two periods per pass on an inverted grid
	localparam int FOLD_W = 36 + $clog2(MAX_FOLDS + 1);
	// Unsigned bin product and the cell number taken from its top bits
	localparam int BIN_W  = Q_W + STEP_W;
	localparam int GRP_W  = BIN_W - 2 * FRAC_BITS;
	// Two integrate stages, one stage per fold pass, three binning stages
	localparam int LATENCY = 2 + MAX_FOLDS + 3;

	typedef enum logic [IDX_W-1:0] {
		REG_TIME_STEP      = 3'd0,
		REG_GRID_LOW       = 3'd1,
		REG_GRID_HIGH      = 3'd2,
		REG_BOUNDARY_MODE  = 3'd3,
		REG_INV_CELL_WIDTH = 3'd4,
		REG_CELL_COUNT     = 3'd5
	} reg_index_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_PERIODIC = 2'd0,
		MODE_REFLECT  = 2'd1,
		MODE_OPEN     = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BELOW     = 2'd1,
		ST_ABOVE     = 2'd2,
		ST_UNSETTLED = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [Q_W-1:0] position;
		logic signed [Q_W-1:0] velocity_x;
		logic signed [Q_W-1:0] e_field;
	} particle_t;

	typedef struct packed {
		logic signed [Q_W-1:0] new_position;
		logic signed [Q_W-1:0] new_velocity_x;
		logic [CELL_W-1:0]     cell_index;
		status_t               status;
	} pushed_t;

	// Raw configuration registers
	typedef struct packed {
		logic [STEP_W-1:0]     time_step;
		logic signed [Q_W-1:0] grid_low;
		logic signed [Q_W-1:0] grid_high;
		logic [MODE_W-1:0]     boundary_mode;
		logic [STEP_W-1:0]     inv_cell_width;
		logic [CNT_W-1:0]      cell_count;
	} cfg_t;

	// Grid values derived from the configuration, held in registers
	typedef struct packed {
		logic signed [FOLD_W-1:0] lo_w;
		logic signed [FOLD_W-1:0] hi_w;
		logic signed [FOLD_W-1:0] lo2;
		logic signed [FOLD_W-1:0] hi2;
		logic signed [FOLD_W-1:0] period;
		logic                     wrap;
		logic                     reflect;
		logic [CNT_W-1:0]         count;
	} geom_t;

	// Particle state while it walks through the fold passes
	typedef struct packed {
		logic signed [FOLD_W-1:0] x;
		logic signed [Q_W-1:0]    v;
		logic                     pinned;
	} fold_t;

	function automatic logic signed [PROD_W-1:0] sx64(input logic signed [Q_W-1:0] a);
		return $signed({{(PROD_W-Q_W){a[Q_W-1]}}, a});
	endfunction

	// Clamp a wide signed value to the 32-bit range
	function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] a);
		logic signed [Q_W-1:0] r;
		if (!a[PROD_W-1] && (|a[PROD_W-2:Q_W-1])) begin
			r = $signed({1'b0, {(Q_W-1){1'b1}}});
		end else if (a[PROD_W-1] && !(&a[PROD_W-2:Q_W-1])) begin
			r = $signed({1'b1, {(Q_W-1){1'b0}}});
		end else begin
			r = a[Q_W-1:0];
		end
		return r;
	endfunction

	// Negate, with the most negative value going to the most positive
	function automatic logic signed [Q_W-1:0] neg_sat32(input logic signed [Q_W-1:0] a);
		logic signed [Q_W-1:0] r;
		if (a == $signed({1'b1, {(Q_W-1){1'b0}}})) begin
			r = $signed({1'b0, {(Q_W-1){1'b1}}});
		end else begin
			r = -a;
		end
		return r;
	endfunction

endpackage

[rtl/ppb_integrate.sv]
// Euler update of position and velocity: multiply stage, then shift, clamp and add stage.
module ppb_integrate (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  ppb_pkg::particle_t            particle,
	input  ppb_pkg::cfg_t                 cfg,
	output logic                          valid_s2,
	output logic signed [ppb_pkg::Q_W-1:0] x_s2,
	output logic signed [ppb_pkg::Q_W-1:0] v_s2
);
	import ppb_pkg::*;

	logic signed [Q_W-1:0]    dt_s;
	logic                     valid_s1;
	logic signed [Q_W-1:0]    pos_s1;
	logic signed [Q_W-1:0]    vel_s1;
	logic signed [PROD_W-1:0] dtv_s1;
	logic signed [PROD_W-1:0] dte_s1;
	logic signed [Q_W-1:0]    dtv_sat;
	logic signed [Q_W-1:0]    dte_sat;
	logic signed [Q_W-1:0]    x_next;
	logic signed [Q_W-1:0]    v_next;

	assign dt_s = $signed({1'b0, cfg.time_step});

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: exact products dt*v and dt*E
	always_ff @(posedge clk) begin
		pos_s1 <= particle.position;
		vel_s1 <= particle.velocity_x;
		dtv_s1 <= dt_s * particle.velocity_x;
		dte_s1 <= dt_s * particle.e_field;
	end

	// Floor shift back to Q16.16, clamp, then saturating add
	always_comb begin
		dtv_sat = sat32(dtv_s1 >>> FRAC_BITS);
		dte_sat = sat32(dte_s1 >>> FRAC_BITS);
		x_next  = sat32(sx64(pos_s1) + sx64(dtv_sat));
		v_next  = sat32(sx64(vel_s1) + sx64(dte_sat));
	end

	// Stage 2
	always_ff @(posedge clk) begin
		x_s2 <= x_next;
		v_s2 <= v_next;
	end

endmodule

[rtl/ppb_fold.sv]
// Boundary folding: one register stage per wrap or reflect pass.
module ppb_fold (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_in,
	input  ppb_pkg::fold_t fold_in,
	input  ppb_pkg::geom_t geom,
	output logic           valid_out,
	output ppb_pkg::fold_t fold_out
);
	import ppb_pkg::*;

	logic [MAX_FOLDS-1:0] valid_s;
	fold_t                fold_s [MAX_FOLDS];

	// One pass: a period shift, or a fold at the high wall then the low wall
	function automatic fold_t fold_pass(input fold_t a, input geom_t g);
		fold_t r;
		logic  in_grid;
		r = a;
		in_grid = (a.x >= g.lo_w) && (a.x < g.hi_w);
		if (g.wrap) begin
			if (a.x >= g.hi_w) begin
				r.x = a.x - g.period;
			end else if (a.x < g.lo_w) begin
				r.x = a.x + g.period;
			end
		end else if (g.reflect && !a.pinned && !in_grid) begin
			if (a.x >= g.hi_w) begin
				r.x      = g.hi2 - a.x;
				r.v      = neg_sat32(r.v);
				r.pinned = (r.x == g.hi_w);
			end
			if (!r.pinned && (r.x < g.lo_w)) begin
				r.x = g.lo2 - r.x;
				r.v = neg_sat32(r.v);
			end
		end
		return r;
	endfunction

	for (genvar k = 0; k < MAX_FOLDS; k++) begin : g_pass
		fold_t src;
		logic  src_valid;

		if (k == 0) begin : g_first
			assign src       = fold_in;
			assign src_valid = valid_in;
		end else begin : g_next
			assign src       = fold_s[k-1];
			assign src_valid = valid_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			fold_s[k] <= fold_pass(src, geom);
		end
	end

	assign valid_out = valid_s[MAX_FOLDS-1];
	assign fold_out  = fold_s[MAX_FOLDS-1];

endmodule

[rtl/ppb_bin.sv]
// Cell binning and status: clamp and offset, scale multiply, range check.
module ppb_bin (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	input  ppb_pkg::fold_t   fold_in,
	input  ppb_pkg::cfg_t    cfg,
	input  ppb_pkg::geom_t   geom,
	output logic             done,
	output ppb_pkg::pushed_t result
);
	import ppb_pkg::*;

	logic                  unsettled;
	logic signed [Q_W-1:0] xs;
	status_t               pre_d;

	logic                  valid_s1;
	logic signed [Q_W-1:0] x_s1;
	logic signed [Q_W-1:0] v_s1;
	status_t               pre_s1;
	logic                  at_hi_s1;
	logic [Q_W-1:0]        diff_s1;

	logic                  valid_s2;
	logic signed [Q_W-1:0] x_s2;
	logic signed [Q_W-1:0] v_s2;
	status_t               pre_s2;
	logic                  at_hi_s2;
	logic [BIN_W-1:0]      prod_s2;

	logic [GRP_W-1:0]      grp;
	pushed_t               res_d;
	logic                  valid_s3;
	pushed_t               result_s3;

	// Settle check, clamp to 32 bits, early status
	always_comb begin
		unsettled = (geom.wrap || (geom.reflect && !fold_in.pinned))
			&& !((fold_in.x >= geom.lo_w) && (fold_in.x < geom.hi_w));
		xs = sat32(PROD_W'(fold_in.x));
		if (unsettled) begin
			pre_d = ST_UNSETTLED;
		end else if (xs < cfg.grid_low) begin
			pre_d = ST_BELOW;
		end else begin
			pre_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: offset from the low bound
	always_ff @(posedge clk) begin
		x_s1     <= xs;
		v_s1     <= fold_in.v;
		pre_s1   <= pre_d;
		at_hi_s1 <= (xs == cfg.grid_high);
		diff_s1  <= Q_W'(xs - cfg.grid_low);
	end

	// Stage 2: scale by the inverse cell width
	always_ff @(posedge clk) begin
		x_s2     <= x_s1;
		v_s2     <= v_s1;
		pre_s2   <= pre_s1;
		at_hi_s2 <= at_hi_s1;
		prod_s2  <= BIN_W'(diff_s1) * BIN_W'(cfg.inv_cell_width);
	end

	// Cell pick and final status
	always_comb begin
		grp                  = prod_s2[BIN_W-1:2*FRAC_BITS];
		res_d.new_position   = x_s2;
		res_d.new_velocity_x = v_s2;
		res_d.cell_index     = '0;
		res_d.status         = pre_s2;
		if (pre_s2 == ST_OK) begin
			if (at_hi_s2) begin
				// exactly on the high wall: last cell
				if (geom.count == '0) begin
					res_d.status = ST_ABOVE;
				end else begin
					res_d.cell_index = CELL_W'(geom.count - 1'b1);
				end
			end else if (grp >= geom.count) begin
				res_d.status = ST_ABOVE;
			end else begin
				res_d.cell_index = CELL_W'(grp);
			end
		end
	end

	// Stage 3: result register
	always_ff @(posedge clk) begin
		result_s3 <= res_d;
	end

	assign done   = valid_s3;
	assign result = result_s3;

endmodule

[rtl/particle_push_boundary_bin.sv]
// Top level: configuration registers, derived grid values and the push pipeline.
//
// One particle beat (position, velocity_x, e_field, signed Q16.16) enters
// when start is high and busy is low. busy stays low: the pipeline takes a
// new beat on every clock, so the throughput is one particle per cycle.
// Each beat yields exactly one result beat on result, marked by a
// one-cycle done strobe, after the Euler multiply and add stages, a
// register stage for each fold pass and the binning stages (the scale
// multiply sits in the middle). Results leave in input order.
// The receiver has no back-pressure; a result not taken in its cycle is gone.
// Configuration goes through cfg_we / cfg_index / cfg_data, one register
// per edge; the user must write only while no particle is in flight, and
// the block itself does not enforce it. Derived grid values are registered
// in the cycle after a write.
// Reset (arst_n low) clears the valid bits, drops any particles in flight
// and returns the configuration registers to their reset values.
module particle_push_boundary_bin (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ppb_pkg::particle_t          particle,
	output logic                        done,
	output ppb_pkg::pushed_t            result,
	input  logic                        cfg_we,
	input  logic [ppb_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ppb_pkg::Q_W-1:0]     cfg_data
);
	import ppb_pkg::*;

	cfg_t                  cfg_q;
	geom_t                 geom_q;
	geom_t                 geom_d;
	logic                  int_valid;
	logic signed [Q_W-1:0] int_x;
	logic signed [Q_W-1:0] int_v;
	fold_t                 fold_start;
	logic                  fold_valid;
	fold_t                 fold_done;

	// Pipeline never stalls
	assign busy = 1'b0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step      <= STEP_W'(65536);
			cfg_q.grid_low       <= '0;
			cfg_q.grid_high      <= Q_W'(65536);
			cfg_q.boundary_mode  <= MODE_PERIODIC;
			cfg_q.inv_cell_width <= STEP_W'(65536);
			cfg_q.cell_count     <= CNT_W'(1);
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_TIME_STEP:      cfg_q.time_step      <= cfg_data[STEP_W-1:0];
				REG_GRID_LOW:       cfg_q.grid_low       <= cfg_data;
				REG_GRID_HIGH:      cfg_q.grid_high      <= cfg_data;
				REG_BOUNDARY_MODE:  cfg_q.boundary_mode  <= cfg_data[MODE_W-1:0];
				REG_INV_CELL_WIDTH: cfg_q.inv_cell_width <= cfg_data[STEP_W-1:0];
				REG_CELL_COUNT:     cfg_q.cell_count     <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Derived grid values; used no earlier than the first fold stage
	always_comb begin
		geom_d.lo_w    = FOLD_W'(cfg_q.grid_low);
		geom_d.hi_w    = FOLD_W'(cfg_q.grid_high);
		geom_d.lo2     = geom_d.lo_w + geom_d.lo_w;
		geom_d.hi2     = geom_d.hi_w + geom_d.hi_w;
		geom_d.period  = geom_d.hi_w - geom_d.lo_w;
		geom_d.wrap    = (cfg_q.boundary_mode == MODE_PERIODIC) && (geom_d.period > 0);
		geom_d.reflect = (cfg_q.boundary_mode == MODE_REFLECT);
		if (32'(cfg_q.cell_count) > 32'(MAX_CELLS)) begin
			geom_d.count = CNT_W'(MAX_CELLS);
		end else begin
			geom_d.count = cfg_q.cell_count;
		end
	end

	always_ff @(posedge clk) begin
		geom_q <= geom_d;
	end

	ppb_integrate u_integrate (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.particle (particle),
		.cfg      (cfg_q),
		.valid_s2 (int_valid),
		.x_s2     (int_x),
		.v_s2     (int_v)
	);

	assign fold_start.x      = FOLD_W'(int_x);
	assign fold_start.v      = int_v;
	assign fold_start.pinned = 1'b0;

	ppb_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (int_valid),
		.fold_in   (fold_start),
		.geom      (geom_q),
		.valid_out (fold_valid),
		.fold_out  (fold_done)
	);

	ppb_bin u_bin (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (fold_valid),
		.fold_in  (fold_done),
		.cfg      (cfg_q),
		.geom     (geom_q),
		.done     (done),
		.result   (result)
	);

	// Every accepted beat comes out after the fixed latency
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("accepted beat did not produce a result");

	// No result without a matching accepted beat
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without an accepted beat");

	// Error results carry cell zero
	a_err_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> (result.cell_index == '0))
		else $error("nonzero cell on an error result");

	// Fold limit only in a folding mode
	a_unsettled_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_UNSETTLED)) |->
		((cfg_q.boundary_mode == MODE_PERIODIC) || (cfg_q.boundary_mode == MODE_REFLECT)))
		else $error("fold limit flagged in open mode");

	// A particle on the high wall lands in the last cell
	a_high_wall: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_OK) && (result.new_position == cfg_q.grid_high)) |->
		(result.cell_index == CELL_W'(geom_q.count - 1'b1)))
		else $error("high wall particle not in last cell");

endmodule

[tb/particle_push_boundary_bin_test.sv]
// Self-checking testbench for the particle push, boundary fold and cell binning pipeline.
`timescale 1ns / 100ps

module particle_push_boundary_bin_test;
	import ppb_pkg::*;

	localparam int  TIMEOUT_CYCLES = 300000;
	localparam int  PHASE_ITEMS    = 168;
	localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint Q_MIN = -64'sh0000_0000_8000_0000;
	// Mode code with no name in the package; the block treats it as open
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	particle_t            particle;
	logic                 done;
	pushed_t              result;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_index;
	logic [Q_W-1:0]       cfg_data;

	// Shadow copy of the configuration registers
	longint               dt_q;
	longint               lo_q;
	longint               hi_q;
	logic [MODE_W-1:0]    mode_q;
	logic [63:0]          inv_q;
	int unsigned          cnt_q;

	particle_t            particles_waiting[$];
	pushed_t              pushed_due[$];
	int                   sender_idle;
	logic                 took_beat;
	int                   bad_beats;
	int                   cycles;

	particle_push_boundary_bin u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.particle  (particle),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic longint clamp32(input longint a);
		longint r;
		r = a;
		if (a > Q_MAX) r = Q_MAX;
		if (a < Q_MIN) r = Q_MIN;
		return r;
	endfunction

	// dt * a, floored back to Q16.16 and saturated
	function automatic longint dt_scaled(input logic signed [Q_W-1:0] a);
		longint prod;
		prod = dt_q * longint'(a);
		return clamp32(prod >>> FRAC_BITS);
	endfunction

	// Euler step, boundary fold and binning for one particle
	function automatic pushed_t push_particle(input particle_t p);
		longint      x;
		longint      v;
		longint      period;
		logic        unsettled;
		logic        pinned;
		logic        stop;
		logic [63:0] diff;
		logic [63:0] grp;
		int unsigned count;
		pushed_t     r;
		unsettled = 1'b0;
		pinned    = 1'b0;
		stop      = 1'b0;
		x = clamp32(longint'(p.position) + dt_scaled(p.velocity_x));
		v = clamp32(longint'(p.velocity_x) + dt_scaled(p.e_field));
		count = (cnt_q > MAX_CELLS) ? MAX_CELLS : cnt_q;

		if (mode_q == MODE_PERIODIC) begin
			period = hi_q - lo_q;
			// empty grid: no wrapping at all
			if (period > 0) begin
				for (int k = 0; k < MAX_FOLDS; k++) begin
					if (x >= hi_q) x = x - period;
					else if (x < lo_q) x = x + period;
				end
				unsettled = (x >= hi_q) || (x < lo_q);
			end
		end else if (mode_q == MODE_REFLECT) begin
			// each pass: mirror at the high wall, then at the low wall
			for (int k = 0; k < MAX_FOLDS; k++) begin
				if (!stop) begin
					if (x < hi_q && x >= lo_q) begin
						stop = 1'b1;
					end else begin
						if (x >= hi_q) begin
							x = 2 * hi_q - x;
							v = clamp32(-v);
							if (x == hi_q) begin
								pinned = 1'b1;
								stop   = 1'b1;
							end
						end
						if (!stop && x < lo_q) begin
							x = 2 * lo_q - x;
							v = clamp32(-v);
						end
					end
				end
			end
			unsettled = !pinned && ((x >= hi_q) || (x < lo_q));
		end

		x = clamp32(x);
		r.new_position   = x[Q_W-1:0];
		r.new_velocity_x = v[Q_W-1:0];
		r.cell_index     = '0;
		r.status         = ST_OK;
		if (unsettled) begin
			r.status = ST_UNSETTLED;
		end else if (x < lo_q) begin
			r.status = ST_BELOW;
		end else if (x == hi_q) begin
			// a position right on the upper wall lands in the last cell
			if (count == 0) r.status = ST_ABOVE;
			else r.cell_index = CELL_W'(count - 1);
		end else begin
			diff = 64'(x - lo_q);
			grp  = (diff * inv_q) >> (2 * FRAC_BITS);
			if (grp >= 64'(count)) r.status = ST_ABOVE;
			else r.cell_index = grp[CELL_W-1:0];
		end
		return r;
	endfunction

	// Random particle, mostly aimed at the grid and its walls
	function automatic particle_t random_particle();
		longint      span;
		longint      target;
		logic [63:0] frac;
		int          pick;
		particle_t   p;
		pick = $urandom_range(0, 9);
		p.position   = $urandom;
		p.velocity_x = $urandom;
		p.e_field    = $urandom;
		if (pick == 2 || pick == 3) begin
			case ($urandom_range(0, 5))
				0: target = lo_q;
				1: target = hi_q;
				2: target = lo_q - 1;
				3: target = hi_q - 1;
				4: target = Q_MIN;
				default: target = Q_MAX;
			endcase
			p.position = Q_W'(clamp32(target));
			if ($urandom_range(0, 1) == 0) p.velocity_x = '0;
		end else if (pick >= 4) begin
			span = hi_q - lo_q;
			if (span <= 0) span = 64'sh1_0000;
			frac = (64'($urandom) * 64'(span)) >> 32;
			target = lo_q + (longint'($urandom_range(0, 4)) - 2) * span + longint'(frac);
			p.position   = Q_W'(clamp32(target));
			p.velocity_x = $signed($urandom) >>> $urandom_range(0, 31);
			p.e_field    = $signed($urandom) >>> $urandom_range(0, 31);
		end
		return p;
	endfunction

	task automatic add_particle(input logic [Q_W-1:0] pos, input logic [Q_W-1:0] vel,
			input logic [Q_W-1:0] ef);
		particle_t p;
		p.position   = pos;
		p.velocity_x = vel;
		p.e_field    = ef;
		particles_waiting.push_back(p);
	endtask

	task automatic put_reg(input reg_index_t idx, input logic [Q_W-1:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		case (idx)
			REG_TIME_STEP:      dt_q  = longint'(d[STEP_W-1:0]);
			REG_GRID_LOW:       lo_q  = longint'($signed(d));
			REG_GRID_HIGH:      hi_q  = longint'($signed(d));
			REG_BOUNDARY_MODE:  mode_q = d[MODE_W-1:0];
			REG_INV_CELL_WIDTH: inv_q = 64'(d[STEP_W-1:0]);
			REG_CELL_COUNT:     cnt_q = d[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Wait until no particle is queued, on the bus or in flight, then let the pipe empty
	task automatic drain();
		while (particles_waiting.size() != 0 || start || pushed_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic configure(input logic [Q_W-1:0] dt, input logic [Q_W-1:0] lo,
			input logic [Q_W-1:0] hi, input logic [Q_W-1:0] mode,
			input logic [Q_W-1:0] inv, input logic [Q_W-1:0] cnt);
		drain();
		put_reg(REG_TIME_STEP, dt);
		put_reg(REG_GRID_LOW, lo);
		put_reg(REG_GRID_HIGH, hi);
		put_reg(REG_BOUNDARY_MODE, mode);
		put_reg(REG_INV_CELL_WIDTH, inv);
		put_reg(REG_CELL_COUNT, cnt);
		@(negedge clk);
		cfg_we <= 1'b0;
		// derived grid values settle in the cycle after the last write
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic random_beats(input int n);
		for (int i = 0; i < n; i++)
			particles_waiting.push_back(random_particle());
	endtask

	// Driver: offers the next particle once the previous beat was taken
	always @(negedge clk) begin
		if (!start || took_beat) begin
			if (particles_waiting.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
				start    <= 1'b1;
				particle <= particles_waiting.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks result beats, then records accepted particles
	always @(posedge clk) begin
		pushed_t want;
		if (!arst_n) begin
			took_beat <= 1'b0;
		end else begin
			if (done) begin
				if (pushed_due.size() == 0) begin
					$error("result beat with nothing outstanding");
					bad_beats++;
				end else begin
					want = pushed_due.pop_front();
					if (result.new_position !== want.new_position) begin
						$error("new_position expected %0d actual %0d",
							want.new_position, result.new_position);
						bad_beats++;
					end
					if (result.new_velocity_x !== want.new_velocity_x) begin
						$error("new_velocity_x expected %0d actual %0d",
							want.new_velocity_x, result.new_velocity_x);
						bad_beats++;
					end
					if (result.cell_index !== want.cell_index) begin
						$error("cell_index expected %0d actual %0d",
							want.cell_index, result.cell_index);
						bad_beats++;
					end
					if (result.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, result.status);
						bad_beats++;
					end
				end
			end
			if (start && !busy)
				pushed_due.push_back(push_particle(particle));
			took_beat <= start && !busy;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		particle    = '0;
		cfg_we      = 1'b0;
		cfg_index   = REG_TIME_STEP;
		cfg_data    = '0;
		took_beat   = 1'b0;
		bad_beats   = 0;
		cycles      = 0;
		sender_idle = 30;
		dt_q   = 64'sh1_0000;
		lo_q   = 0;
		hi_q   = 64'sh1_0000;
		mode_q = MODE_PERIODIC;
		inv_q  = 64'h1_0000;
		cnt_q  = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Periodic wrap on the reset grid [0, 1.0), one cell
		add_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_particle(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		add_particle(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'h0000_FFFF, 32'h0000_0000, 32'h0000_8000);
		add_particle(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'h0003_0000, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'hFFFE_0000, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'h0000_8000, 32'h0000_8000, 32'hFFFF_0000);
		add_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

		// Reflective walls: pinned at the top, single folds, saturating negation
		configure(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'(MODE_REFLECT),
			32'h0001_0000, 32'd1);
		add_particle(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'h0000_8000, 32'h0000_C000, 32'h0000_0000);
		add_particle(32'hFFFF_C000, 32'h0000_0000, 32'h0000_1000);
		add_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		add_particle(32'h0003_8000, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'h0005_8000, 32'h0000_0000, 32'h0000_0000);

		// Open boundary: below, on the top wall, above
		configure(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'(MODE_OPEN),
			32'h0001_0000, 32'd1);
		add_particle(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		add_particle(32'h0002_0000, 32'h0000_0000, 32'h0000_0000);

		// Random phases, sender idling 30 percent
		configure(32'h0000_8000, 32'hFFFC_0000, 32'h0004_0000, 32'(MODE_PERIODIC),
			32'h0002_0000, 32'd16);
		random_beats(PHASE_ITEMS);
		configure(32'h0000_8000, 32'hFFFC_0000, 32'h0004_0000, 32'(MODE_REFLECT),
			32'h0002_0000, 32'd16);
		random_beats(PHASE_ITEMS);
		configure(32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'(MODE_REFLECT),
			32'h0010_0000, 32'd16);
		random_beats(PHASE_ITEMS);
		configure(32'h0001_0000, 32'hFF9C_0000, 32'h0064_0000, 32'(MODE_OPEN),
			32'h0000_1000, 32'd13);
		random_beats(PHASE_ITEMS);

		// Extreme grids and counts, sender idling 78 percent
		drain();
		sender_idle = 78;
		configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'(MODE_SPARE),
			32'h7FFF_FFFF, 32'd4096);
		random_beats(PHASE_ITEMS);
		configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'(MODE_PERIODIC),
			32'h0000_0100, 32'd8191);
		random_beats(PHASE_ITEMS);
		// inverted grid, no time step, zero cells
		configure(32'h0000_0000, 32'h0005_0000, 32'hFFFB_0000, 32'(MODE_PERIODIC),
			32'h0001_0000, 32'd0);
		random_beats(PHASE_ITEMS);
		// inverted reflective grid; high data bits must be dropped
		configure(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFD,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_beats(PHASE_ITEMS);

		// Random configurations, sender never idles
		drain();
		sender_idle = 0;
		configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		random_beats(PHASE_ITEMS);
		for (int ph = 0; ph < 2; ph++) begin
			logic signed [Q_W-1:0] lo_pick;
			lo_pick = $signed($urandom) >>> $urandom_range(8, 31);
			configure($urandom_range(0, 32'h0004_0000), lo_pick,
				Q_W'(clamp32(longint'(lo_pick) + longint'($urandom_range(1, 32'h0010_0000)))),
				$urandom_range(0, 3), $urandom_range(0, 32'h0040_0000),
				$urandom_range(0, 8191));
			random_beats(PHASE_ITEMS);
		end

		drain();
		if (bad_beats == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
